// ===== design/mips_imm_pkg.sv =====
// Shared types for the MIPS immediate ALU and COP2 move core.
// Holds the instruction kind and exception encodings and the ALU result struct.
// Used by mips_imm_alu and mips64_immediate_alu_cop2_move_core; no dependencies.
`default_nettype none

package mips_imm_pkg;

    localparam int unsigned XLEN     = 64;
    localparam int unsigned REG_AW   = 5;
    localparam int unsigned REG_NUM  = 32;
    localparam int unsigned IMM_W    = 16;

    typedef enum logic [3:0] {
        KIND_ANDI   = 4'd0,
        KIND_ADDI   = 4'd1,
        KIND_ADDIU  = 4'd2,
        KIND_DADDI  = 4'd3,
        KIND_DADDIU = 4'd4,
        KIND_LUI    = 4'd5,
        KIND_ORI    = 4'd6,
        KIND_XORI   = 4'd7,
        KIND_SLTI   = 4'd8,
        KIND_SLTIU  = 4'd9,
        KIND_MFC2   = 4'd10,
        KIND_DMFC2  = 4'd11,
        KIND_MTC2   = 4'd12,
        KIND_DMTC2  = 4'd13,
        KIND_CXC2   = 4'd14,
        KIND_COP2   = 4'd15
    } t_kind;

    typedef enum logic [1:0] {
        EXC_NONE     = 2'd0,
        EXC_OVERFLOW = 2'd1,
        EXC_CPU      = 2'd2,
        EXC_RI       = 2'd3
    } t_exc;

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            write;
        t_exc            exc;
        logic            latch_we;
    } t_alu_res;

endpackage

`default_nettype wire

// ===== design/mips_imm_alu.sv =====
// Execute logic for one immediate-format or COP2 move instruction.
// Depends on mips_imm_pkg for the kind and exception codes and the result struct.
`default_nettype none

module mips_imm_alu (
    input  var mips_imm_pkg::t_kind                 i_kind,
    input  wire logic [mips_imm_pkg::IMM_W-1:0]     i_imm,
    input  wire logic [mips_imm_pkg::XLEN-1:0]      i_opnd,
    input  wire logic [mips_imm_pkg::XLEN-1:0]      i_latch,
    input  wire logic                               i_usable,
    output mips_imm_pkg::t_alu_res                  o_res
);

    logic [63:0] simm;
    logic [63:0] zimm;
    logic [31:0] sum32;
    logic [63:0] sum64;
    logic        ovf32;
    logic        ovf64;

    assign simm  = {{48{i_imm[15]}}, i_imm};
    assign zimm  = {48'd0, i_imm};
    assign sum32 = i_opnd[31:0] + simm[31:0];
    assign sum64 = i_opnd + simm;
    assign ovf32 = (i_opnd[31] ^ sum32[31]) & (simm[31] ^ sum32[31]);
    assign ovf64 = (i_opnd[63] ^ sum64[63]) & (simm[63] ^ sum64[63]);

    always_comb begin
        o_res.value    = '0;
        o_res.write    = 1'b0;
        o_res.exc      = mips_imm_pkg::EXC_NONE;
        o_res.latch_we = 1'b0;
        case (i_kind)
            mips_imm_pkg::KIND_ANDI: begin
                o_res.value = i_opnd & zimm;
                o_res.write = 1'b1;
            end
            mips_imm_pkg::KIND_ADDI: begin
                if (ovf32) begin
                    o_res.exc = mips_imm_pkg::EXC_OVERFLOW;
                end else begin
                    o_res.value = {{32{sum32[31]}}, sum32};
                    o_res.write = 1'b1;
                end
            end
            mips_imm_pkg::KIND_ADDIU: begin
                o_res.value = {{32{sum32[31]}}, sum32};
                o_res.write = 1'b1;
            end
            mips_imm_pkg::KIND_DADDI: begin
                if (ovf64) begin
                    o_res.exc = mips_imm_pkg::EXC_OVERFLOW;
                end else begin
                    o_res.value = sum64;
                    o_res.write = 1'b1;
                end
            end
            mips_imm_pkg::KIND_DADDIU: begin
                o_res.value = sum64;
                o_res.write = 1'b1;
            end
            mips_imm_pkg::KIND_LUI: begin
                o_res.value = {{32{i_imm[15]}}, i_imm, 16'd0};
                o_res.write = 1'b1;
            end
            mips_imm_pkg::KIND_ORI: begin
                o_res.value = i_opnd | zimm;
                o_res.write = 1'b1;
            end
            mips_imm_pkg::KIND_XORI: begin
                o_res.value = i_opnd ^ zimm;
                o_res.write = 1'b1;
            end
            mips_imm_pkg::KIND_SLTI: begin
                o_res.value = {63'd0, $signed(i_opnd) < $signed(simm)};
                o_res.write = 1'b1;
            end
            mips_imm_pkg::KIND_SLTIU: begin
                o_res.value = {63'd0, i_opnd < simm};
                o_res.write = 1'b1;
            end
            default: begin
                // All coprocessor 2 kinds land here.
                if (!i_usable) begin
                    o_res.exc = mips_imm_pkg::EXC_CPU;
                end else if (i_kind == mips_imm_pkg::KIND_MFC2) begin
                    o_res.value = {{32{i_latch[31]}}, i_latch[31:0]};
                    o_res.write = 1'b1;
                end else if (i_kind == mips_imm_pkg::KIND_DMFC2) begin
                    o_res.value = i_latch;
                    o_res.write = 1'b1;
                end else if (i_kind == mips_imm_pkg::KIND_MTC2 ||
                             i_kind == mips_imm_pkg::KIND_DMTC2) begin
                    o_res.latch_we = 1'b1;
                end else if (i_kind == mips_imm_pkg::KIND_COP2) begin
                    o_res.exc = mips_imm_pkg::EXC_RI;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mips64_immediate_alu_cop2_move_core.sv =====
// Top level of the MIPS immediate ALU and COP2 move core.
// Depends on mips_imm_pkg and mips_imm_alu.
//
// Usage: each input transaction carries one instruction (kind, rs, rt, immediate)
// and produces exactly one output transaction (rt, written value, write flag,
// exception code). Both channels use valid/ready. The configuration channel
// writes the COP2 usable bit; it is always ready and should be used while idle.
// At the edge that accepts the input, the synchronous register file read is
// issued from the input ports into the execute stage; execute and write-back
// into the output register follow when the execute stage advances.
// Throughput is one instruction per cycle while the receiver does not stall;
// a dependent instruction right behind its producer gets the new value through
// a bypass of the last register file write, so there is no interlock bubble.
// When the receiver stalls, the output register holds its transaction, the
// execute stage holds behind it and the input is then held off; nothing is lost.
// Reset clears the valid bits of all 32 registers (so they read as zero), the
// COP2 latch, the usable bit and all pipeline valids. It is synchronous and
// takes effect at a rising clock edge while i_rst_n is low.
`default_nettype none

module mips64_immediate_alu_cop2_move_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output wire logic        o_cfg_ready,
    input  wire logic        i_cfg_data,
    input  wire logic        i_in_valid,
    output wire logic        o_in_ready,
    input  wire logic [3:0]  i_kind,
    input  wire logic [4:0]  i_src_index,
    input  wire logic [4:0]  i_dst_index,
    input  wire logic [15:0] i_immediate,
    output wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    output wire logic [4:0]  o_dest_index,
    output wire logic [63:0] o_dest_value,
    output wire logic        o_dest_written,
    output wire logic [1:0]  o_exception_code
);

    localparam int unsigned AW = mips_imm_pkg::REG_AW;
    localparam int unsigned DW = mips_imm_pkg::XLEN;

    // Register file storage and per-entry valid bits.
    logic [DW-1:0]                    r_mem [mips_imm_pkg::REG_NUM];
    logic [mips_imm_pkg::REG_NUM-1:0] r_valid;

    logic          r_usable;
    logic [DW-1:0] r_latch;

    // Execute stage.
    logic                   r_s1_valid;
    mips_imm_pkg::t_kind    r_s1_kind;
    logic [AW-1:0]          r_s1_rt;
    logic [AW-1:0]          r_s1_raddr;
    logic [15:0]            r_s1_imm;
    logic [DW-1:0]          r_rd_data;
    logic                   r_rd_valid;

    // Bypass of the most recent register file write.
    logic          r_fw_valid;
    logic [AW-1:0] r_fw_idx;
    logic [DW-1:0] r_fw_data;

    // Output register.
    logic                r_out_valid;
    logic [AW-1:0]       r_out_idx;
    logic [DW-1:0]       r_out_value;
    logic                r_out_written;
    mips_imm_pkg::t_exc  r_out_exc;

    logic                   in_accept;
    logic                   s1_adv;
    logic [AW-1:0]          rd_addr;
    mips_imm_pkg::t_kind    in_kind;
    logic [DW-1:0]          opnd;
    mips_imm_pkg::t_alu_res alu_res;
    logic                   wb_we;
    logic [DW-1:0]          wb_value;

    assign in_kind   = mips_imm_pkg::t_kind'(i_kind);
    assign s1_adv    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // MTC2 and DMTC2 take their source from rt; everything else reads rs.
    assign rd_addr = (in_kind == mips_imm_pkg::KIND_MTC2 ||
                      in_kind == mips_imm_pkg::KIND_DMTC2) ? i_dst_index : i_src_index;

    always_comb begin
        if (r_fw_valid && r_fw_idx == r_s1_raddr) begin
            opnd = r_fw_data;
        end else if (r_rd_valid) begin
            opnd = r_rd_data;
        end else begin
            opnd = '0;
        end
    end

    mips_imm_alu u_alu (
        .i_kind   (r_s1_kind),
        .i_imm    (r_s1_imm),
        .i_opnd   (opnd),
        .i_latch  (r_latch),
        .i_usable (r_usable),
        .o_res    (alu_res)
    );

    // Register zero never takes a write.
    assign wb_we    = alu_res.write && (r_s1_rt != '0);
    assign wb_value = wb_we ? alu_res.value : '0;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (s1_adv && wb_we) begin
            r_mem[r_s1_rt] <= wb_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_usable    <= 1'b0;
            r_latch     <= '0;
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_usable <= i_cfg_data;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && wb_we) begin
                r_valid[r_s1_rt] <= 1'b1;
                r_fw_valid       <= 1'b1;
            end
            if (s1_adv && alu_res.latch_we) begin
                r_latch <= opnd;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind  <= in_kind;
            r_s1_rt    <= i_dst_index;
            r_s1_raddr <= rd_addr;
            r_s1_imm   <= i_immediate;
            r_rd_valid <= r_valid[rd_addr];
        end
        if (s1_adv && wb_we) begin
            r_fw_idx  <= r_s1_rt;
            r_fw_data <= wb_value;
        end
        if (s1_adv) begin
            r_out_idx     <= r_s1_rt;
            r_out_value   <= wb_value;
            r_out_written <= wb_we;
            r_out_exc     <= alu_res.exc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_dest_index     = r_out_idx;
    assign o_dest_value     = r_out_value;
    assign o_dest_written   = r_out_written;
    assign o_exception_code = r_out_exc;

endmodule

`default_nettype wire

// ===== tb/sv/mips64_immediate_alu_cop2_move_core_test.sv =====
// Self-checking testbench for mips64_immediate_alu_cop2_move_core.
// Runs directed and random instruction streams against an internal execute-stage
// predictor with its own register file and COP2 latch; depends on mips_imm_pkg.
module mips64_immediate_alu_cop2_move_core_test;
    import mips_imm_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_ENTRIES  = 60;
    localparam int PHASE_INSNS   = 100;

    typedef enum logic [1:0] {ACT_INSN, ACT_CFG, ACT_DRAIN} act_t;

    typedef struct packed {
        act_t        act;
        t_kind       kind;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic        usable;
    } stream_t;

    typedef struct packed {
        logic [4:0]  idx;
        logic [63:0] value;
        logic        written;
        t_exc        exc;
    } wb_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_kind       i_kind = KIND_ANDI;
    logic [4:0]  i_src_index = '0;
    logic [4:0]  i_dst_index = '0;
    logic [15:0] i_immediate = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [4:0]  o_dest_index;
    logic [63:0] o_dest_value;
    logic        o_dest_written;
    logic [1:0]  o_exception_code;

    // Predictor state, owned by the driver process.
    logic [63:0] gpr [32];
    logic [63:0] cop2_latch;
    logic        cop2_on;

    stream_t insn_stream [$];
    wb_t     wb_expected [$];
    int      n_issued = 0;
    int      n_retired = 0;
    int      n_errors = 0;
    int      n_planned = 0;
    logic    tail = 1'b0;

    mips64_immediate_alu_cop2_move_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_src_index      (i_src_index),
        .i_dst_index      (i_dst_index),
        .i_immediate      (i_immediate),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_dest_index     (o_dest_index),
        .o_dest_value     (o_dest_value),
        .o_dest_written   (o_dest_written),
        .o_exception_code (o_exception_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Executes one instruction on the predictor state and returns its write-back.
    function automatic wb_t execute_insn(t_kind kind, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
        logic [63:0] a;
        logic [63:0] simm;
        logic [63:0] sum;
        logic [31:0] sum32;
        logic [63:0] val;
        logic        wr;
        t_exc        exc;
        wb_t         r;
        a = (rs == 5'd0) ? 64'd0 : gpr[rs];
        simm = {{48{imm[15]}}, imm};
        val = '0;
        wr = 1'b0;
        exc = EXC_NONE;
        sum32 = a[31:0] + simm[31:0];
        sum = a + simm;
        case (kind)
            KIND_ANDI: begin
                val = a & {48'd0, imm};
                wr = 1'b1;
            end
            KIND_ADDI: begin
                if (a[31] == imm[15] && sum32[31] != a[31]) begin
                    exc = EXC_OVERFLOW;
                end else begin
                    val = {{32{sum32[31]}}, sum32};
                    wr = 1'b1;
                end
            end
            KIND_ADDIU: begin
                val = {{32{sum32[31]}}, sum32};
                wr = 1'b1;
            end
            KIND_DADDI: begin
                if (a[63] == imm[15] && sum[63] != a[63]) begin
                    exc = EXC_OVERFLOW;
                end else begin
                    val = sum;
                    wr = 1'b1;
                end
            end
            KIND_DADDIU: begin
                val = sum;
                wr = 1'b1;
            end
            KIND_LUI: begin
                val = {{32{imm[15]}}, imm, 16'd0};
                wr = 1'b1;
            end
            KIND_ORI: begin
                val = a | {48'd0, imm};
                wr = 1'b1;
            end
            KIND_XORI: begin
                val = a ^ {48'd0, imm};
                wr = 1'b1;
            end
            KIND_SLTI: begin
                val = ($signed(a) < $signed(simm)) ? 64'd1 : 64'd0;
                wr = 1'b1;
            end
            KIND_SLTIU: begin
                val = (a < simm) ? 64'd1 : 64'd0;
                wr = 1'b1;
            end
            default: begin
                if (!cop2_on) begin
                    exc = EXC_CPU;
                end else begin
                    case (kind)
                        KIND_MFC2: begin
                            val = {{32{cop2_latch[31]}}, cop2_latch[31:0]};
                            wr = 1'b1;
                        end
                        KIND_DMFC2: begin
                            val = cop2_latch;
                            wr = 1'b1;
                        end
                        KIND_MTC2, KIND_DMTC2: cop2_latch = (rt == 5'd0) ? 64'd0 : gpr[rt];
                        KIND_COP2: exc = EXC_RI;
                        default: ;
                    endcase
                end
            end
        endcase
        if (rt == 5'd0) wr = 1'b0;
        if (wr) gpr[rt] = val;
        else val = '0;
        r.idx = rt;
        r.value = val;
        r.written = wr;
        r.exc = exc;
        return r;
    endfunction

    // Driver: presents queued instructions and configuration writes, and
    // predicts each instruction at the edge where its transaction is accepted.
    int   gap_left = 0;
    int   settle = 0;
    int   drv_cycle = 0;
    logic drv_gaps_on = 1'b1;

    always @(posedge i_clk) begin
        logic    in_busy;
        logic    cfg_busy;
        stream_t nxt;
        wb_t     wb;
        if (!i_rst_n) begin
            foreach (gpr[i]) gpr[i] = '0;
            cop2_latch = '0;
            cop2_on = 1'b0;
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            in_busy = i_in_valid;
            cfg_busy = i_cfg_valid;
            if (i_in_valid && o_in_ready) begin
                wb = execute_insn(i_kind, i_src_index, i_dst_index, i_immediate);
                wb_expected.push_back(wb);
                n_issued <= n_issued + 1;
                in_busy = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cop2_on = i_cfg_data;
                cfg_busy = 1'b0;
            end
            if (n_retired == n_issued && !i_in_valid && !i_cfg_valid) settle++;
            else settle = 0;
            drv_cycle++;
            if (drv_cycle % 64 == 0) drv_gaps_on = $urandom_range(0, 3) != 0;

            if (!in_busy && !cfg_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (insn_stream.size() > 0) begin
                    nxt = insn_stream[0];
                    case (nxt.act)
                        ACT_INSN: begin
                            void'(insn_stream.pop_front());
                            in_busy = 1'b1;
                            i_kind <= nxt.kind;
                            i_src_index <= nxt.rs;
                            i_dst_index <= nxt.rt;
                            i_immediate <= nxt.imm;
                            if (drv_gaps_on && insn_stream.size() >= TAIL_ENTRIES
                                && $urandom_range(0, 4) == 0)
                                gap_left = $urandom_range(1, 4);
                        end
                        default: begin
                            // Register writes and pauses wait until the core has drained.
                            if (settle >= SETTLE_CYCLES) begin
                                void'(insn_stream.pop_front());
                                if (nxt.act == ACT_CFG) begin
                                    cfg_busy = 1'b1;
                                    i_cfg_data <= nxt.usable;
                                end
                            end
                        end
                    endcase
                end
            end
            i_in_valid <= in_busy;
            i_cfg_valid <= cfg_busy;
            tail <= insn_stream.size() < TAIL_ENTRIES;
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    int   stall_left = 0;
    int   mon_cycle = 0;
    logic mon_stalls_on = 1'b1;

    always @(posedge i_clk) begin
        wb_t  want;
        logic rdy;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (n_retired == n_issued) begin
                    $error("unexpected result: dest_index %0d, dest_value %h",
                           o_dest_index, o_dest_value);
                    n_errors++;
                end else begin
                    want = wb_expected.pop_front();
                    n_retired <= n_retired + 1;
                    if (o_dest_index !== want.idx) begin
                        $error("dest_index: expected %0d, got %0d", want.idx, o_dest_index);
                        n_errors++;
                    end
                    if (o_dest_value !== want.value) begin
                        $error("dest_value: expected %h, got %h", want.value, o_dest_value);
                        n_errors++;
                    end
                    if (o_dest_written !== want.written) begin
                        $error("dest_written: expected %0d, got %0d", want.written,
                               o_dest_written);
                        n_errors++;
                    end
                    if (o_exception_code !== want.exc) begin
                        $error("exception_code: expected %0d, got %0d", want.exc,
                               o_exception_code);
                        n_errors++;
                    end
                end
            end
            mon_cycle++;
            if (mon_cycle % 64 == 32) mon_stalls_on = $urandom_range(0, 3) != 0;
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (mon_stalls_on && !tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_out_ready <= rdy;
        end
    end

    task automatic push_insn(t_kind kind, logic [4:0] rs, logic [4:0] rt, logic [15:0] imm);
        stream_t s;
        s.act = ACT_INSN;
        s.kind = kind;
        s.rs = rs;
        s.rt = rt;
        s.imm = imm;
        s.usable = 1'b0;
        insn_stream.push_back(s);
        n_planned++;
    endtask

    task automatic push_ctl(act_t act, logic usable);
        stream_t s;
        s = '0;
        s.act = act;
        s.kind = KIND_ANDI;
        s.usable = usable;
        insn_stream.push_back(s);
    endtask

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'h0001;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random instructions, with chains that build a value near a sign boundary
    // and then operate on it, so that overflow and compare corners are reached.
    task automatic push_random_insn();
        logic [4:0] r;
        if ($urandom_range(0, 3) == 0) begin
            r = pick_reg();
            push_insn(KIND_LUI, pick_reg(), r,
                      $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            push_insn(KIND_ORI, r, r, pick_imm());
            push_insn(t_kind'($urandom_range(0, 9)), r, pick_reg(), pick_imm());
        end else begin
            push_insn(t_kind'($urandom_range(0, 15)), pick_reg(), pick_reg(), pick_imm());
        end
    endtask

    initial begin
        int target;
        push_ctl(ACT_CFG, 1'b0);
        push_insn(KIND_LUI,    5'd0,  5'd1,  16'h7FFF);
        push_insn(KIND_ORI,    5'd1,  5'd1,  16'hFFFF);
        push_insn(KIND_ADDI,   5'd1,  5'd2,  16'h0001);
        push_insn(KIND_ADDIU,  5'd1,  5'd2,  16'h0001);
        push_insn(KIND_DADDIU, 5'd1,  5'd5,  16'h0001);
        push_insn(KIND_LUI,    5'd0,  5'd3,  16'h8000);
        push_insn(KIND_ADDI,   5'd3,  5'd4,  16'hFFFF);
        push_insn(KIND_DADDI,  5'd3,  5'd4,  16'hFFFF);
        push_insn(KIND_ANDI,   5'd4,  5'd6,  16'hFFFF);
        push_insn(KIND_XORI,   5'd3,  5'd7,  16'hFFFF);
        push_insn(KIND_SLTI,   5'd3,  5'd8,  16'h0000);
        push_insn(KIND_SLTIU,  5'd8,  5'd9,  16'hFFFF);
        push_insn(KIND_LUI,    5'd0,  5'd0,  16'hFFFF);
        push_insn(KIND_MFC2,   5'd0,  5'd10, 16'h0000);
        push_insn(KIND_COP2,   5'd0,  5'd10, 16'h0000);
        push_ctl(ACT_CFG, 1'b1);
        push_insn(KIND_DMTC2,  5'd0,  5'd4,  16'h0000);
        push_insn(KIND_MFC2,   5'd0,  5'd11, 16'h0000);
        push_insn(KIND_DMFC2,  5'd0,  5'd12, 16'h0000);
        push_insn(KIND_MTC2,   5'd0,  5'd3,  16'h0000);
        push_insn(KIND_MFC2,   5'd0,  5'd13, 16'h0000);
        push_insn(KIND_CXC2,   5'd3,  5'd14, 16'hFFFF);
        push_insn(KIND_COP2,   5'd3,  5'd15, 16'hFFFF);
        push_insn(KIND_DMFC2,  5'd0,  5'd0,  16'h0000);
        push_insn(KIND_SLTI,   5'd1,  5'd16, 16'h8000);
        push_insn(KIND_ADDIU,  5'd31, 5'd31, 16'h7FFF);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) push_ctl(ACT_CFG, 1'b0);
            else if (ph == 1) push_ctl(ACT_CFG, 1'b1);
            else push_ctl(ACT_CFG, 1'($urandom_range(0, 1)));
            target = n_planned + PHASE_INSNS;
            while (n_planned < target) begin
                push_random_insn();
                // A mid-phase pause with the pipeline fully drained.
                if (ph == 3 && n_planned == target - PHASE_INSNS / 2)
                    push_ctl(ACT_DRAIN, 1'b0);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk);
        while (insn_stream.size() != 0 || i_in_valid || i_cfg_valid || n_retired != n_issued);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && wb_expected.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
design/mips_imm_pkg.sv
design/mips_imm_alu.sv
design/mips64_immediate_alu_cop2_move_core.sv
tb/sv/mips64_immediate_alu_cop2_move_core_test.sv
